### design/vdh_pkg.sv
// shared types, constants and helpers for the vertex dedup hash indexer
`timescale 1ns / 1ps

package vdh_pkg;

  // table geometry; depth is a power of two so the first probe is the hash masked
  localparam int TABLE_DEPTH = 8192;
  localparam int MAX_UNIQUE  = 65536;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(MAX_UNIQUE + 1);

  localparam int COUNT_W = 24;
  localparam int REF_W   = 25;
  localparam int VIDX_W  = 16;

  localparam logic [31:0] MIX_C1 = 32'h7feb352d;
  localparam logic [31:0] MIX_C2 = 32'h846ca68b;

  // configuration register indexes
  localparam logic [1:0] CFG_POSITION_COUNT = 2'd0;
  localparam logic [1:0] CFG_TEXCOORD_COUNT = 2'd1;
  localparam logic [1:0] CFG_NORMAL_COUNT   = 2'd2;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_BAD_POSITION = 2'd1,
    STATUS_FULL         = 2'd2
  } status_t;

  typedef struct packed {
    logic                    valid;
    logic [COUNT_W-1:0]      pos_key;
    logic signed [REF_W-1:0] tex_key;
    logic signed [REF_W-1:0] nrm_key;
    logic [VIDX_W-1:0]       vidx;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // positive is one-based, negative counts back from cnt, zero is missing
  function automatic logic signed [REF_W-1:0] resolve_ref(
    input logic signed [REF_W-1:0] r,
    input logic [COUNT_W-1:0]      cnt
  );
    logic signed [REF_W-1:0] res;
    if (r > 0) begin
      res = r - REF_W'(1);
    end else if (r < 0) begin
      res = $signed({1'b0, cnt}) + r;
    end else begin
      res = -REF_W'(1);
    end
    return res;
  endfunction

  function automatic logic [31:0] shr_xor(input logic [31:0] x, input int sh);
    return x ^ (x >> sh);
  endfunction

endpackage

### design/vdh_ram.sv
// generic simple dual port ram, one write port, one registered read port
`timescale 1ns / 1ps

module vdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/vertex_dedup_hash_indexer.sv
// top level: corner reference resolver, iterative hash mixer and linear probe table
`timescale 1ns / 1ps

// Deduplicates mesh corner references one at a time. After reset the block
// clears its 8192-entry table, one entry per cycle, and s_tready stays low
// until the pass is done (configuration writes are taken meanwhile). Each
// item is then accepted, resolved, hashed (three keys, each through the one
// shared 32x32 multiplier twice plus a fold), looked up by linear probing
// (each probe a registered read of the table RAM and a compare) and handed
// to the output register, a hand-off that waits while the output is stalled.
// Items with an invalid position reference skip hashing and probing.
// The output register lets the next item be accepted while a result waits.
module vertex_dedup_hash_indexer (
  input  logic                         clk,
  input  logic                         rst,
  // beat fields from bit 0: raw_position_ref, raw_texcoord_ref, raw_normal_ref
  input  logic [79:0]                  s_tdata,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // fields from bit 0: vertex_index, position_slot, texcoord_slot, normal_slot
  output logic [95:0]                  m_tdata,
  // fields from bit 0: is_new, status
  output logic [2:0]                   m_tuser,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [vdh_pkg::COUNT_W-1:0]  cfg_data
);

  import vdh_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RESOLVE,
    S_MUL1,
    S_MUL2,
    S_FOLD,
    S_READ,
    S_CMP,
    S_EMIT
  } state_t;

  state_t state;

  logic [COUNT_W-1:0] position_count;
  logic [COUNT_W-1:0] texcoord_count;
  logic [COUNT_W-1:0] normal_count;

  logic signed [REF_W-1:0] raw_pos;
  logic signed [REF_W-1:0] raw_tex;
  logic signed [REF_W-1:0] raw_nrm;

  logic [COUNT_W-1:0]      pos_key;
  logic signed [REF_W-1:0] tex_key;
  logic signed [REF_W-1:0] nrm_key;

  logic [31:0] mix_x;
  logic [31:0] hash_acc;
  logic [1:0]  key_sel;
  logic [IDX_W-1:0] probe_addr;
  logic [IDX_W-1:0] probe_cnt;
  logic [IDX_W-1:0] clr_addr;
  logic [CNT_W-1:0] unique_count;

  logic [VIDX_W-1:0] res_vidx;
  logic              res_new;
  status_t           res_status;

  logic [VIDX_W-1:0]       out_vidx;
  logic                    out_new;
  logic [COUNT_W-1:0]      out_pos;
  logic signed [REF_W-1:0] out_tex;
  logic signed [REF_W-1:0] out_nrm;
  status_t                 out_status;

  // resolution
  logic signed [REF_W-1:0] pos_res;
  logic signed [REF_W-1:0] tex_res;
  logic signed [REF_W-1:0] nrm_res;
  logic                    pos_bad;

  // shared multiplier
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_full;
  logic [31:0] mix_fin;
  logic [31:0] hash_next;
  logic [31:0] next_key;

  // table
  entry_t           rd_entry;
  entry_t           new_entry;
  logic [ENTRY_W-1:0] rd_data;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic               key_match;
  logic               has_room;
  logic [IDX_W-1:0]   probe_addr_next;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      position_count <= '0;
      texcoord_count <= '0;
      normal_count   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_POSITION_COUNT: position_count <= cfg_data;
        CFG_TEXCOORD_COUNT: texcoord_count <= cfg_data;
        CFG_NORMAL_COUNT:   normal_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_res = resolve_ref(raw_pos, position_count);
    tex_res = resolve_ref(raw_tex, texcoord_count);
    nrm_res = resolve_ref(raw_nrm, normal_count);
    pos_bad = pos_res[REF_W-1] || (pos_res[COUNT_W-1:0] >= position_count);
  end

  always_comb begin
    if (state == S_MUL1) begin
      mul_a = mix_x;
      mul_b = MIX_C1;
    end else begin
      mul_a = shr_xor(mix_x, 15);
      mul_b = MIX_C2;
    end
    mul_full = mul_a * mul_b;
    mix_fin  = shr_xor(mix_x, 16);
    unique case (key_sel)
      2'd0:    hash_next = hash_acc ^ mix_fin;
      2'd1:    hash_next = hash_acc ^ {mix_fin[30:0], 1'b0};
      default: hash_next = hash_acc ^ {mix_fin[29:0], 2'b00};
    endcase
    // sign-extended key that follows the current one
    if (key_sel == 2'd0) begin
      next_key = {{(32-REF_W){tex_key[REF_W-1]}}, tex_key};
    end else begin
      next_key = {{(32-REF_W){nrm_key[REF_W-1]}}, nrm_key};
    end
  end

  always_comb begin
    rd_entry  = entry_t'(rd_data);
    key_match = (rd_entry.pos_key == pos_key) && (rd_entry.tex_key == tex_key) &&
                (rd_entry.nrm_key == nrm_key);
    has_room  = unique_count < CNT_W'(MAX_UNIQUE);
    probe_addr_next = (probe_addr == IDX_W'(TABLE_DEPTH - 1)) ? '0 : probe_addr + 1'b1;

    new_entry.valid   = 1'b1;
    new_entry.pos_key = pos_key;
    new_entry.tex_key = tex_key;
    new_entry.nrm_key = nrm_key;
    new_entry.vidx    = unique_count[VIDX_W-1:0];

    wr_en   = 1'b0;
    wr_addr = probe_addr;
    wr_data = new_entry;
    if (state == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = '0;
    end else if (state == S_CMP && !rd_entry.valid && has_room) begin
      wr_en = 1'b1;
    end
  end

  vdh_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (state == S_READ),
    .rd_addr (probe_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      unique_count <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // in S_EMIT the output register is reloaded below instead
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == IDX_W'(TABLE_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_tvalid) begin
            raw_pos <= $signed(s_tdata[REF_W-1:0]);
            raw_tex <= $signed(s_tdata[2*REF_W-1:REF_W]);
            raw_nrm <= $signed(s_tdata[3*REF_W-1:2*REF_W]);
            state   <= S_RESOLVE;
          end
        end
        S_RESOLVE: begin
          tex_key  <= tex_res;
          nrm_key  <= nrm_res;
          key_sel  <= 2'd0;
          hash_acc <= '0;
          if (pos_bad) begin
            pos_key    <= '0;
            res_vidx   <= '0;
            res_new    <= 1'b0;
            res_status <= STATUS_BAD_POSITION;
            state      <= S_EMIT;
          end else begin
            pos_key <= pos_res[COUNT_W-1:0];
            mix_x   <= shr_xor({{(32-COUNT_W){1'b0}}, pos_res[COUNT_W-1:0]}, 16);
            state   <= S_MUL1;
          end
        end
        S_MUL1: begin
          mix_x <= mul_full[31:0];
          state <= S_MUL2;
        end
        S_MUL2: begin
          mix_x <= mul_full[31:0];
          state <= S_FOLD;
        end
        S_FOLD: begin
          hash_acc <= hash_next;
          if (key_sel == 2'd2) begin
            probe_addr <= hash_next[IDX_W-1:0];
            probe_cnt  <= '0;
            state      <= S_READ;
          end else begin
            key_sel <= key_sel + 1'b1;
            mix_x   <= shr_xor(next_key, 16);
            state   <= S_MUL1;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          priority if (!rd_entry.valid) begin
            if (has_room) begin
              res_vidx     <= unique_count[VIDX_W-1:0];
              res_new      <= 1'b1;
              res_status   <= STATUS_OK;
              unique_count <= unique_count + 1'b1;
            end else begin
              res_vidx   <= '0;
              res_new    <= 1'b0;
              res_status <= STATUS_FULL;
            end
            state <= S_EMIT;
          end else if (key_match) begin
            res_vidx   <= rd_entry.vidx;
            res_new    <= 1'b0;
            res_status <= STATUS_OK;
            state      <= S_EMIT;
          end else if (probe_cnt == IDX_W'(TABLE_DEPTH - 1)) begin
            // every entry probed without a match or a free slot
            res_vidx   <= '0;
            res_new    <= 1'b0;
            res_status <= STATUS_FULL;
            state      <= S_EMIT;
          end else begin
            probe_addr <= probe_addr_next;
            probe_cnt  <= probe_cnt + 1'b1;
            state      <= S_READ;
          end
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid   <= 1'b1;
            out_vidx   <= res_vidx;
            out_new    <= res_new;
            out_pos    <= pos_key;
            out_tex    <= tex_key;
            out_nrm    <= nrm_key;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tdata = {6'b0, out_nrm, out_tex, out_pos, out_vidx};
  assign m_tuser = {out_status, out_new};

endmodule

### design/vdh_checker.sv
// port-level checker for the vertex dedup hash indexer, bound to the top level
`timescale 1ns / 1ps

module vdh_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [95:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tvalid,
  input logic        m_tready
);

  import vdh_pkg::*;

  // table clearing pass keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready right after reset");

  // one item in flight: ready drops after every accepted beat
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second beat accepted back to back");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output beat changed");

  // errors never report an index or an insert
  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:1] != STATUS_OK) |-> (m_tdata[15:0] == 16'd0) && !m_tuser[0])
    else $error("error beat carries a vertex index");

  a_bad_pos_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:1] == STATUS_BAD_POSITION) |-> (m_tdata[39:16] == 24'd0))
    else $error("invalid position beat carries a position slot");

endmodule

bind vertex_dedup_hash_indexer vdh_checker u_vdh_checker (.*);
